// ===== sv/pli_pkg.sv =====
// Package for the positional list insert/delete block.
// Holds the item structs, the operation and status codes and the sequencer states.
// Used by positional_list_insert_delete_top; depends on nothing else.
package pli_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TAKE,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    op_e                operation;
    logic [7:0]         position;
    logic signed [31:0] insert_value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [7:0]         list_length;
  } out_item_t;

endpackage

// ===== sv/positional_list_insert_delete_top.sv =====
// Top level of the positional list: element memory, length count and move sequencer.
// One memory port pair is shared by every element move under a small state machine.
// Depends on pli_pkg.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-----------------------
//   input   | in_valid_i | in_stall_o  | in_item_i  (in_item_t)
//   output  | out_valid_o| out_stall_i | out_item_o (out_item_t)
//
// An item moves one element at a time (memory read, then write): an insert or a delete
// walks every element behind the position before its result is written to the result
// register, while a rejected item goes straight from the check to the result.
// Reset clears the length and the control state; the element memory is not cleared.
// The input is stalled while an item is being worked on. The result waits in an
// output register, and the next item can be accepted while that result is stalled.
module positional_list_insert_delete_top
  import pli_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = ((CW > 8) ? CW : 8) + 1;

  seq_state_e state_q, state_d;
  in_item_t   req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  status_e    status_q, status_d;
  logic signed [31:0] removed_q, removed_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_wdata;

  logic [XW-1:0] pos_x, cnt_x, idx_x;
  logic          ins_bad, del_bad, full;
  logic          out_free;

  assign pos_x    = XW'(req_q.position);
  assign cnt_x    = XW'(count_q);
  assign idx_x    = XW'(idx_q);
  assign ins_bad  = (req_q.position == 8'd0) || (pos_x > cnt_x + XW'(1));
  assign del_bad  = (req_q.position == 8'd0) || (pos_x > cnt_x);
  assign full     = (count_q == CW'(CAPACITY));
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (req_q.operation == OP_INSERT) begin
          if (ins_bad || full) state_d = S_DONE;
          else if (cnt_x >= pos_x) state_d = S_RD;
          else state_d = S_PUT;
        end else begin
          state_d = del_bad ? S_DONE : S_TAKE;
        end
      end
      S_TAKE: begin
        state_d = (pos_x < cnt_x) ? S_RD : S_DONE;
      end
      S_RD: state_d = S_WR;
      S_WR: begin
        if (req_q.operation == OP_INSERT) begin
          state_d = (idx_x > pos_x) ? S_RD : S_PUT;
        end else begin
          state_d = (idx_x + XW'(1) < cnt_x) ? S_RD : S_DONE;
        end
      end
      S_PUT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    req_d       = req_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = '0;
    mem_waddr   = '0;
    mem_wdata   = rdata_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) req_d = in_item_i;
      end
      S_CHECK: begin
        removed_d = '0;
        idx_d     = count_q;
        if (req_q.operation == OP_INSERT) begin
          if (ins_bad) status_d = ST_RANGE;
          else if (full) status_d = ST_FULL;
          else status_d = ST_OK;
        end else begin
          status_d = del_bad ? ST_RANGE : ST_OK;
          // Fetch the element being removed.
          mem_re    = !del_bad;
          mem_raddr = AW'(pos_x - XW'(1));
        end
      end
      S_TAKE: begin
        removed_d = rdata_q;
        idx_d     = CW'(pos_x);
      end
      S_RD: begin
        mem_re = 1'b1;
        if (req_q.operation == OP_INSERT) mem_raddr = AW'(idx_q - CW'(1));
        else mem_raddr = AW'(idx_q);
      end
      S_WR: begin
        mem_we = 1'b1;
        if (req_q.operation == OP_INSERT) begin
          mem_waddr = AW'(idx_q);
          idx_d     = idx_q - CW'(1);
        end else begin
          mem_waddr = AW'(idx_q - CW'(1));
          idx_d     = idx_q + CW'(1);
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_x - XW'(1));
        mem_wdata = req_q.insert_value;
        count_d   = count_q + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          if (req_q.operation == OP_DELETE && status_q == ST_OK) begin
            count_d = count_q - CW'(1);
          end
          out_valid_d                = 1'b1;
          out_item_d.status          = status_q;
          out_item_d.removed_value   = removed_q;
          out_item_d.list_length     = 8'(XW'(count_d));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the list by one");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && (state_q == S_IDLE || state_q == S_DONE)))
    else $error("memory written outside an element move");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_OK) |-> out_item_o.removed_value == '0)
    else $error("rejected item returned a nonzero value");

endmodule
